>>> rtl/core/phh_pkg.sv
// Shared constants, types and index helpers for the pixel hit histogram.
package phh_pkg;

  // Histogram geometry and counter width
  localparam int COORD_BITS  = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int INDEX_BITS  = 2 * COORD_BITS;
  localparam int NUM_BINS    = 1 << INDEX_BITS;

  // Packet layout
  localparam int COL_SHIFT = 56;
  localparam int ROW_SHIFT = 48;

  // Channel field widths
  localparam int ACTION_W    = 1;
  localparam int PACKET_W    = 64;
  localparam int BIN_INDEX_W = 16;
  localparam int BIN_COUNT_W = 32;
  localparam int READ_IDX_W  = 16;

  // Item codes
  localparam logic [ACTION_W-1:0] ACT_HIT        = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_READ_CLEAR = 1'b1;

  typedef logic [INDEX_BITS-1:0]  bin_addr_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [COORD_BITS-1:0]  coord_t;

  localparam count_t COUNT_MAX = '1;

  // Bin address of a hit packet: column + row << COORD_BITS
  function automatic bin_addr_t bin_of_packet(input logic [PACKET_W-1:0] pw);
    coord_t col;
    coord_t row;
    col = COORD_BITS'(pw >> COL_SHIFT);
    row = COORD_BITS'(pw >> ROW_SHIFT);
    return {row, col};
  endfunction

  // Bin address of a read-and-clear item, masked (or zero-extended) to the store
  function automatic bin_addr_t bin_of_index(input logic [BIN_INDEX_W-1:0] bi);
    logic [31:0] wide;
    wide = 32'(bi);
    return INDEX_BITS'(wide);
  endfunction

  // Reported index, folded back onto the 16-bit result field
  function automatic logic [READ_IDX_W-1:0] report_index(input bin_addr_t ix);
    logic [31:0] wide;
    wide = 32'(ix);
    return READ_IDX_W'(wide);
  endfunction

  // Reported count: low 32 bits of the counter
  function automatic logic [BIN_COUNT_W-1:0] report_count(input count_t c);
    logic [63:0] wide;
    wide = 64'(c);
    return BIN_COUNT_W'(wide);
  endfunction

endpackage

>>> rtl/core/phh_if.sv
// Valid/ready channel interfaces for histogram items and read results.
interface phh_in_if;
  logic                            valid;
  logic                            ready;
  logic [phh_pkg::ACTION_W-1:0]    action;
  logic [phh_pkg::PACKET_W-1:0]    packet_word;
  logic [phh_pkg::BIN_INDEX_W-1:0] bin_index;

  modport source (output valid, output action, output packet_word, output bin_index,
                  input ready);
  modport sink   (input valid, input action, input packet_word, input bin_index,
                  output ready);
endinterface

interface phh_out_if;
  logic                            valid;
  logic                            ready;
  logic [phh_pkg::BIN_COUNT_W-1:0] bin_count;
  logic [phh_pkg::READ_IDX_W-1:0]  read_index;

  modport source (output valid, output bin_count, output read_index, input ready);
  modport sink   (input valid, input bin_count, input read_index, output ready);
endinterface

>>> rtl/core/pixel_hit_histogram.sv
// 2-D pixel hit histogram: saturating bin counters in one synchronous RAM.
//
// After reset the block runs a clearing pass that zeroes the 65536-bin store,
// one bin per cycle, during which in_ch.ready stays low. Then for every item
// the transfer cycle issues the RAM read of the addressed bin, and the next
// cycle modifies the registered read data and writes it back; the bin RAM's
// registered read port sets this order. A hit item bumps its bin, saturating
// at the counter maximum, and gives no result; a read-and-clear item returns
// the bin's count with its index and zeroes the bin. Results sit in an output
// register, so a new item is taken while a result waits; a read-and-clear
// item that finds the output register still occupied holds in its write-back
// cycle until it drains.
module pixel_hit_histogram (
  input  logic      clk,
  input  logic      rst_n,
  phh_in_if.sink    in_ch,
  phh_out_if.source out_ch
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_MODIFY = 2'd2;

  // Bin store
  phh_pkg::count_t mem [phh_pkg::NUM_BINS];

  logic [1:0]                      state_r, state_nxt;
  phh_pkg::bin_addr_t              clr_addr_r, clr_addr_nxt;
  logic [phh_pkg::ACTION_W-1:0]    act_r, act_nxt;
  phh_pkg::bin_addr_t              addr_r, addr_nxt;
  phh_pkg::count_t                 rd_data_r;

  logic                            out_valid_r, out_valid_nxt;
  logic [phh_pkg::BIN_COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [phh_pkg::READ_IDX_W-1:0]  out_index_r, out_index_nxt;

  logic                            in_fire;
  logic                            out_free;
  logic                            rd_en;
  phh_pkg::bin_addr_t              rd_addr;
  logic                            wr_en;
  phh_pkg::bin_addr_t              wr_addr;
  phh_pkg::count_t                 wr_data;
  phh_pkg::count_t                 bumped;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.bin_count  = out_count_r;
  assign out_ch.read_index = out_index_r;

  // Read address of the incoming item
  assign rd_en   = in_fire;
  assign rd_addr = (in_ch.action == phh_pkg::ACT_READ_CLEAR)
                   ? phh_pkg::bin_of_index(in_ch.bin_index)
                   : phh_pkg::bin_of_packet(in_ch.packet_word);

  // Saturating increment
  assign bumped = (rd_data_r == phh_pkg::COUNT_MAX) ? rd_data_r
                                                    : rd_data_r + phh_pkg::count_t'(1);

  // Sequencer: clearing pass, accept, read-modify-write
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    act_nxt       = act_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_count_nxt = out_count_r;
    out_index_nxt = out_index_r;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_data       = bumped;

    case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
        clr_addr_nxt = clr_addr_r + phh_pkg::bin_addr_t'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          act_nxt   = in_ch.action;
          addr_nxt  = rd_addr;
          state_nxt = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        if (act_r == phh_pkg::ACT_HIT) begin
          wr_en     = 1'b1;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          wr_en         = 1'b1;
          wr_data       = '0;
          out_valid_nxt = 1'b1;
          out_count_nxt = phh_pkg::report_count(rd_data_r);
          out_index_nxt = phh_pkg::report_index(addr_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    addr_r      <= addr_nxt;
    out_count_r <= out_count_nxt;
    out_index_r <= out_index_nxt;
  end

  // Bin RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
